[sv/sfcrc_pkg.sv]
// shared types, constants and crc step function for the sensor frame crc checker
package sfcrc_pkg;

  localparam int unsigned FRAME_BYTES   = 20;
  localparam int unsigned PAYLOAD_BYTES = 16;
  localparam int unsigned WORD_COUNT    = PAYLOAD_BYTES / 2;
  localparam int unsigned POS_W         = 6;
  localparam int unsigned CAP_IDX_W     = $clog2(PAYLOAD_BYTES);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [31:0]      CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0]      CRC_INIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic               crc_ok;
    logic [15:0]        battery_raw;
    logic signed [15:0] yaw_raw;
    logic [15:0]        ir_left_raw;
    logic [15:0]        ir_right_raw;
    logic [15:0]        speed_raw;
    logic [15:0]        ultrasonic_raw;
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] yaw_rate_raw;
    logic [31:0]        frame_residue;
  } out_beat_t;

  typedef struct packed {
    logic at_last;
    logic fire;
  } asm_status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[sv/sfcrc_assembler.sv]
// byte counter, running crc, payload capture and last good word store
module sfcrc_assembler (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  sfcrc_pkg::in_beat_t    beat_i,
  output sfcrc_pkg::asm_status_t status_o,
  output sfcrc_pkg::out_beat_t   result_o
);
  import sfcrc_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d, pos_eff;
  logic [31:0]      crc_q, crc_d, crc_base, crc_next;
  logic [7:0]       cap_q [PAYLOAD_BYTES];
  logic [15:0]      good_q [WORD_COUNT];
  logic [15:0]      good_d [WORD_COUNT];
  logic             is_final, crc_ok;

  always_comb begin
    pos_eff  = beat_i.frame_start ? '0 : pos_q;
    crc_base = beat_i.frame_start ? CRC_INIT : crc_q;
    crc_next = crc_byte(crc_base, beat_i.data_byte);
    is_final = (pos_eff == LAST_POS);
    crc_ok   = (crc_next == '0);
    pos_d    = pos_q;
    crc_d    = crc_q;
    if (take_i) begin
      pos_d = is_final ? '0 : pos_eff + POS_W'(1);
      crc_d = is_final ? CRC_INIT : crc_next;
    end
    for (int i = 0; i < WORD_COUNT; i++) begin
      good_d[i] = good_q[i];
      if (take_i && is_final && crc_ok) begin
        good_d[i] = {cap_q[2*i], cap_q[2*i+1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= CRC_INIT;
      for (int i = 0; i < WORD_COUNT; i++) begin
        good_q[i] <= '0;
      end
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      good_q <= good_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && (pos_eff < POS_W'(PAYLOAD_BYTES))) begin
      cap_q[pos_eff[CAP_IDX_W-1:0]] <= beat_i.data_byte;
    end
  end

  assign status_o.at_last = (pos_q == LAST_POS);
  assign status_o.fire    = take_i && is_final;

  always_comb begin
    result_o.crc_ok         = crc_ok;
    result_o.battery_raw    = good_d[0];
    result_o.yaw_raw        = good_d[1];
    result_o.ir_left_raw    = good_d[2];
    result_o.ir_right_raw   = good_d[3];
    result_o.speed_raw      = good_d[4];
    result_o.ultrasonic_raw = good_d[5];
    result_o.accel_x_raw    = good_d[6];
    result_o.yaw_rate_raw   = good_d[7];
    result_o.frame_residue  = crc_next;
  end

endmodule

[sv/sensor_frame_crc_checker_unit.sv]
// top level: frame byte intake and registered result beat for the crc checker
// the result beat is registered: it appears in the cycle after the last frame byte is taken
// throughput: one byte per cycle when not stalled; the crc step for a byte is combinational
// a byte waits only at the frame end position while an earlier result beat is stalled
// reset: byte position zero, crc all ones, last good words zero, no result valid
module sensor_frame_crc_checker_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sfcrc_pkg::in_beat_t  in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sfcrc_pkg::out_beat_t out_beat_o
);
  import sfcrc_pkg::*;

  asm_status_t status;
  out_beat_t   result;
  out_beat_t   out_q;
  logic        out_valid_q, out_valid_d;
  logic        take;

  assign in_stall_o = out_valid_q && out_stall_i && status.at_last;
  assign take       = in_valid_i && !in_stall_o;

  sfcrc_assembler u_asm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .beat_i   (in_beat_i),
    .status_o (status),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (status.fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_fire_gives_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fire |=> out_valid_o)
    else $error("last frame byte did not produce a result beat");

  a_ok_matches_residue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.crc_ok == (out_beat_o.frame_residue == 32'h0)))
    else $error("crc_ok disagrees with residue");

  a_fire_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fire |=> !status.at_last)
    else $error("byte position not restarted after frame end");

endmodule

[tb/tb_top.sv]
// testbench for the sensor frame crc checker: frame byte drivers, crc predictor and result scoreboard
module tb_top;
  import sfcrc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_BYTES = 300;

  class frame_tracker;
    logic [31:0] crc;
    logic [5:0]  pos;
    logic [7:0]  capture [PAYLOAD_BYTES];
    logic [15:0] good_words [WORD_COUNT];
    out_beat_t   due_results [$];
    int          failures;

    function new();
      crc = CRC_INIT;
      pos = '0;
      failures = 0;
      foreach (capture[i]) capture[i] = '0;
      foreach (good_words[i]) good_words[i] = '0;
    endfunction

    // bit-serial msb-first crc-32/mpeg-2 update over one byte
    function logic [31:0] crc_after(logic [31:0] c, logic [7:0] d);
      logic [31:0] r;
      logic        fb;
      r = c;
      for (int k = 7; k >= 0; k--) begin
        fb = r[31] ^ d[k];
        r = r << 1;
        if (fb) r = r ^ CRC_POLY;
      end
      return r;
    endfunction

    function void take_byte(in_beat_t b);
      logic [5:0]  at;
      logic [31:0] residue;
      out_beat_t   r;
      if (b.frame_start) begin
        pos = '0;
        crc = CRC_INIT;
      end
      at = pos;
      crc = crc_after(crc, b.data_byte);
      if (at < PAYLOAD_BYTES) capture[at] = b.data_byte;
      if (int'(at) + 1 < FRAME_BYTES) begin
        pos = at + 6'd1;
        return;
      end
      residue = crc;
      pos = '0;
      crc = CRC_INIT;
      if (residue == 32'h0) begin
        for (int i = 0; i < WORD_COUNT; i++) good_words[i] = {capture[2*i], capture[2*i+1]};
      end
      r.crc_ok         = (residue == 32'h0);
      r.battery_raw    = good_words[0];
      r.yaw_raw        = good_words[1];
      r.ir_left_raw    = good_words[2];
      r.ir_right_raw   = good_words[3];
      r.speed_raw      = good_words[4];
      r.ultrasonic_raw = good_words[5];
      r.accel_x_raw    = good_words[6];
      r.yaw_rate_raw   = good_words[7];
      r.frame_residue  = residue;
      due_results = {due_results, r};
    endfunction

    function string describe(out_beat_t v);
      return $sformatf("ok=%b words=%h %h %h %h %h %h %h %h residue=%h", v.crc_ok,
                       v.battery_raw, v.yaw_raw, v.ir_left_raw, v.ir_right_raw, v.speed_raw,
                       v.ultrasonic_raw, v.accel_x_raw, v.yaw_rate_raw, v.frame_residue);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (due_results.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result beat with none due: %s", describe(got));
        return;
      end
      want = due_results.pop_front();
      if (got.crc_ok !== want.crc_ok || got.battery_raw !== want.battery_raw ||
          got.yaw_raw !== want.yaw_raw || got.ir_left_raw !== want.ir_left_raw ||
          got.ir_right_raw !== want.ir_right_raw || got.speed_raw !== want.speed_raw ||
          got.ultrasonic_raw !== want.ultrasonic_raw || got.accel_x_raw !== want.accel_x_raw ||
          got.yaw_rate_raw !== want.yaw_rate_raw ||
          got.frame_residue !== want.frame_residue) begin
        failures++;
        if (failures <= 10) begin
          $display("result mismatch");
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction

    function int waiting();
      return due_results.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  int send_idle_pct;
  int recv_stall_pct;
  int bytes_sent;
  int quiet_cycles;
  bit resync_due;

  frame_tracker tracker;

  sensor_frame_crc_checker_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.take_byte(in_beat);
      if (out_valid && !out_stall) tracker.check_result(out_beat);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] d, input logic s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_beat  <= {8'($urandom), 1'($urandom)};
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{data_byte: d, frame_start: s};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [127:0] payload, input logic lead_start, input int cut,
                            input bit spoil);
    logic [7:0]  frame [FRAME_BYTES];
    logic [31:0] c;
    int          k;
    c = CRC_INIT;
    for (int i = 0; i < FRAME_BYTES - 4; i++) begin
      frame[i] = (i < PAYLOAD_BYTES) ? payload[127-8*i -: 8] : 8'($urandom);
      c = tracker.crc_after(c, frame[i]);
    end
    for (int i = 0; i < 4; i++) frame[FRAME_BYTES-4+i] = c[31-8*i -: 8];
    if (spoil) begin
      k = $urandom_range(FRAME_BYTES - 1);
      frame[k] = frame[k] ^ (8'h01 << $urandom_range(7));
    end
    for (int i = 0; i < cut; i++) send_byte(frame[i], (i == 0) ? lead_start : 1'b0);
  endtask

  task automatic random_traffic(input int upto);
    logic [127:0] payload;
    int           kind;
    logic         lead;
    while (bytes_sent < upto) begin
      kind = $urandom_range(99);
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        case ($urandom_range(9))
          0: payload[127-8*i -: 8] = 8'h00;
          1: payload[127-8*i -: 8] = 8'hFF;
          default: payload[127-8*i -: 8] = 8'($urandom);
        endcase
      end
      lead = resync_due ? ($urandom_range(9) != 0) : 1'($urandom);
      resync_due = 1'b0;
      if (kind < 70) begin
        send_frame(payload, lead, FRAME_BYTES, 1'b0);
      end else if (kind < 82) begin
        send_frame(payload, lead, FRAME_BYTES, 1'b1);
      end else if (kind < 92) begin
        send_frame(payload, lead, $urandom_range(FRAME_BYTES - 1, 1), 1'b0);
        resync_due = 1'b1;
      end else begin
        repeat ($urandom_range(8, 1)) send_byte(8'($urandom), $urandom_range(3) == 0);
        resync_due = 1'b1;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    out_stall = 1'b0;
    bytes_sent = 0;
    quiet_cycles = 0;
    resync_due = 1'b0;
    send_idle_pct = 32;
    recv_stall_pct = 75;
    tracker = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // partial frame dropped by a start flag, then a good frame of extreme words
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_frame(128'hFFFF_8000_0000_FFFF_0000_FFFF_7FFF_8000, 1'b1, FRAME_BYTES, 1'b0);

    random_traffic(PHASE_BYTES);
    send_idle_pct = 75;
    recv_stall_pct = 32;
    random_traffic(2 * PHASE_BYTES);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_traffic(3 * PHASE_BYTES);
    in_valid <= 1'b0;

    while (tracker.waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
